>>> hw/rtl/pncy_pkg.sv
`timescale 1ns / 1ps

package pncy_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int IDX_W           = 4;
    localparam int COMP_W          = 8;
    localparam int DIST_W          = 10;
    localparam int THR_W           = 10;
    localparam int SUM_W           = 26;

    localparam logic [THR_W-1:0] THR_RESET = 10'd40;

    // Fixed-point weights with 16 fractional bits.
    localparam logic signed [SUM_W-1:0] C_Y_R   = 26'sd19595;
    localparam logic signed [SUM_W-1:0] C_Y_G   = 26'sd38470;
    localparam logic signed [SUM_W-1:0] C_Y_B   = 26'sd7471;
    localparam logic signed [SUM_W-1:0] C_Y_OFS = 26'sd32767;
    localparam logic signed [SUM_W-1:0] C_CB_R  = -26'sd11059;
    localparam logic signed [SUM_W-1:0] C_CB_G  = -26'sd21709;
    localparam logic signed [SUM_W-1:0] C_CB_B  = 26'sd32767;
    localparam logic signed [SUM_W-1:0] C_CR_R  = 26'sd32767;
    localparam logic signed [SUM_W-1:0] C_CR_G  = -26'sd27439;
    localparam logic signed [SUM_W-1:0] C_CR_B  = -26'sd5329;
    // Rounding offset plus the chroma bias of 128 in the integer part.
    localparam logic signed [SUM_W-1:0] C_C_OFS = 26'sd8421376;

    typedef enum logic [0:0] {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [COMP_W-1:0] comp_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        op_t   op;
        idx_t  idx;
        comp_t y;
        comp_t cb;
        comp_t cr;
        dist_t best_d;
        idx_t  best_i;
    } beat_t;

endpackage

>>> hw/rtl/pncy_channels.sv
`timescale 1ns / 1ps

interface pncy_pix_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [pncy_pkg::IDX_W-1:0]      entry_index;
    logic [pncy_pkg::COMP_W-1:0]     red;
    logic [pncy_pkg::COMP_W-1:0]     green;
    logic [pncy_pkg::COMP_W-1:0]     blue;

    modport source (output valid, output operation, output entry_index,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input operation, input entry_index,
                    input red, input green, input blue, output ready);
endinterface

interface pncy_res_if;
    logic                            valid;
    logic                            ready;
    logic [pncy_pkg::IDX_W-1:0]      color_index;
    logic [pncy_pkg::DIST_W-1:0]     distance;
    logic                            far_flag;

    modport source (output valid, output color_index, output distance,
                    output far_flag, input ready);
    modport sink   (input valid, input color_index, input distance,
                    input far_flag, output ready);
endinterface

interface pncy_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pncy_pkg::THR_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pncy_conv.sv
`timescale 1ns / 1ps

module pncy_conv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        in_valid,
    input  logic                        operation,
    input  logic [pncy_pkg::IDX_W-1:0]  entry_index,
    input  logic [pncy_pkg::COMP_W-1:0] red,
    input  logic [pncy_pkg::COMP_W-1:0] green,
    input  logic [pncy_pkg::COMP_W-1:0] blue,
    output logic                        out_valid,
    output pncy_pkg::beat_t             out_beat
);
    import pncy_pkg::*;

    logic signed [SUM_W-1:0] rs, gs, bs;
    logic signed [SUM_W-1:0] sum_y, sum_cb, sum_cr;
    logic                    valid_reg;
    beat_t                   beat_reg;
    beat_t                   beat_next;

    always_comb
    begin
        rs = $signed({{(SUM_W-COMP_W){1'b0}}, red});
        gs = $signed({{(SUM_W-COMP_W){1'b0}}, green});
        bs = $signed({{(SUM_W-COMP_W){1'b0}}, blue});
        // All three sums stay in 0 .. 2^24-1, so bits 23:16 are the result.
        sum_y  = rs * C_Y_R  + gs * C_Y_G  + bs * C_Y_B  + C_Y_OFS;
        sum_cb = rs * C_CB_R + gs * C_CB_G + bs * C_CB_B + C_C_OFS;
        sum_cr = rs * C_CR_R + gs * C_CR_G + bs * C_CR_B + C_C_OFS;

        beat_next.op     = op_t'(operation);
        beat_next.idx    = entry_index;
        beat_next.y      = sum_y[23:16];
        beat_next.cb     = sum_cb[23:16];
        beat_next.cr     = sum_cr[23:16];
        beat_next.best_d = '0;
        beat_next.best_i = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> hw/rtl/pncy_cell.sv
`timescale 1ns / 1ps

module pncy_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pncy_pkg::IDX_W-1:0] cell_id,
    input  logic                       take,
    input  logic                       in_valid,
    input  pncy_pkg::beat_t            in_beat,
    output logic                       out_valid,
    output pncy_pkg::beat_t            out_beat
);
    import pncy_pkg::*;

    comp_t              ent_y_reg, ent_cb_reg, ent_cr_reg;
    logic               valid_reg;
    beat_t              beat_reg;
    beat_t              beat_next;
    logic [COMP_W-1:0]  dy, dcb, dcr;
    dist_t              d;
    logic               load_hit;

    always_comb
    begin
        dy  = (ent_y_reg  > in_beat.y)  ? ent_y_reg  - in_beat.y  : in_beat.y  - ent_y_reg;
        dcb = (ent_cb_reg > in_beat.cb) ? ent_cb_reg - in_beat.cb : in_beat.cb - ent_cb_reg;
        dcr = (ent_cr_reg > in_beat.cr) ? ent_cr_reg - in_beat.cr : in_beat.cr - ent_cr_reg;
        d   = DIST_W'(dy) + DIST_W'(dcb) + DIST_W'(dcr);

        load_hit  = in_valid && (in_beat.op == OP_LOAD) && (in_beat.idx == cell_id);

        beat_next = in_beat;
        // The first cell always seeds the running best; later cells replace
        // it only when strictly closer, so the lowest index wins a tie.
        if ((in_beat.op == OP_CLASSIFY) && ((cell_id == '0) || (d < in_beat.best_d)))
        begin
            beat_next.best_d = d;
            beat_next.best_i = cell_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= beat_next;
        end
        if (take && load_hit)
        begin
            ent_y_reg  <= in_beat.y;
            ent_cb_reg <= in_beat.cb;
            ent_cr_reg <= in_beat.cr;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> hw/rtl/nearest_palette_color_ycbcr.sv
`timescale 1ns / 1ps

// Nearest palette color search in YCbCr space.
// The pixel channel carries load beats (operation 0), which write one palette
// entry, and classify beats (operation 1), which carry one RGB pixel. Each
// classify beat gives one beat on the result channel: the lowest palette
// index at the smallest Y+Cb+Cr L1 distance, that distance, and far_flag
// when the distance exceeds the threshold. Load beats give no result.
// The cfg channel writes the threshold; it is always ready. Write it only
// while no beat is in flight.
// A beat is converted to YCbCr in one stage, then walks a row of one cell
// per palette entry, each holding its converted entry. A load beat is kept
// by its own cell on the way past, so order between loads and pixels holds.
// Throughput is one beat per cycle while the result channel is not stalled; a
// result passes the conversion register, every cell register of the row and
// the output register. When the result receiver stalls, beats pile up in the
// row and the pixel channel stays ready until every stage is full.
// Reset clears the valid bits and sets the threshold to 40; palette entries
// must be loaded before the first classify beat.
module nearest_palette_color_ycbcr (
    input  logic      clk,
    input  logic      rst_n,
    pncy_pix_if.sink  pixel,
    pncy_res_if.source result,
    pncy_cfg_if.sink  cfg
);
    import pncy_pkg::*;

    logic [PALETTE_ENTRIES:0] stage_valid;
    logic [PALETTE_ENTRIES:0] stage_take;
    beat_t                    stage_beat [PALETTE_ENTRIES+1];
    logic                     out_take;

    logic [THR_W-1:0]         thr_reg;
    logic                     out_valid_reg;
    idx_t                     out_index_reg;
    dist_t                    out_dist_reg;
    logic                     out_far_reg;
    beat_t                    last_beat;

    // A stage takes a new beat when it is empty or its beat moves on.
    always_comb
    begin
        out_take = !out_valid_reg || result.ready;
        stage_take[PALETTE_ENTRIES] = !stage_valid[PALETTE_ENTRIES] || out_take;
        for (int s = PALETTE_ENTRIES - 1; s >= 0; s--)
        begin
            stage_take[s] = !stage_valid[s] || stage_take[s+1];
        end
    end

    assign pixel.ready = stage_take[0];
    assign cfg.ready   = 1'b1;
    assign last_beat   = stage_beat[PALETTE_ENTRIES];

    pncy_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (stage_take[0]),
        .in_valid    (pixel.valid),
        .operation   (pixel.operation),
        .entry_index (pixel.entry_index),
        .red         (pixel.red),
        .green       (pixel.green),
        .blue        (pixel.blue),
        .out_valid   (stage_valid[0]),
        .out_beat    (stage_beat[0])
    );

    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        pncy_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (IDX_W'(k)),
            .take      (stage_take[k+1]),
            .in_valid  (stage_valid[k]),
            .in_beat   (stage_beat[k]),
            .out_valid (stage_valid[k+1]),
            .out_beat  (stage_beat[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                thr_reg <= cfg.data;
            end
            if (out_take)
            begin
                // Load beats end their walk here without a result.
                out_valid_reg <= stage_valid[PALETTE_ENTRIES] && (last_beat.op == OP_CLASSIFY);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_index_reg <= last_beat.best_i;
            out_dist_reg  <= last_beat.best_d;
            out_far_reg   <= (DIST_W'(last_beat.best_d) > thr_reg);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.color_index = out_index_reg;
    assign result.distance    = out_dist_reg;
    assign result.far_flag    = out_far_reg;

endmodule

>>> hw/rtl/pncy_checker.sv
`timescale 1ns / 1ps

module pncy_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    input  logic                        pix_ready,
    input  logic                        pix_operation,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic [pncy_pkg::IDX_W-1:0]  res_color_index,
    input  logic [pncy_pkg::DIST_W-1:0] res_distance,
    input  logic                        res_far_flag,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [pncy_pkg::THR_W-1:0]  cfg_data
);
    import pncy_pkg::*;

    logic [5:0]       pending_reg;
    logic [5:0]       pending_next;
    logic [THR_W-1:0] thr_reg;
    logic             pix_in;
    logic             res_out;

    assign pix_in  = pix_valid && pix_ready && (pix_operation == OP_CLASSIFY);
    assign res_out = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg + 6'(pix_in) - 6'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            thr_reg     <= THR_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // A stalled result holds its beat.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_color_index)
            && $stable(res_distance) && $stable(res_far_flag))
        else $error("result beat changed while stalled");

    // Every result belongs to a classify beat accepted before it.
    a_res_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 6'd0)
        else $error("result beat without a pending classify beat");

    // The flag follows the distance and the threshold last written.
    a_far_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_far_flag == (res_distance > thr_reg))
        else $error("far_flag disagrees with distance and threshold");

    // The distance of three 8-bit differences never passes 765.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_distance <= 10'd765)
        else $error("distance out of range");

endmodule

bind nearest_palette_color_ycbcr pncy_checker u_pncy_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pixel.valid),
    .pix_ready       (pixel.ready),
    .pix_operation   (pixel.operation),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_color_index (result.color_index),
    .res_distance    (result.distance),
    .res_far_flag    (result.far_flag),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .cfg_data        (cfg.data)
);
